FILE: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath types for the text console
// writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam logic [7:0] NEWLINE_CODE      = 8'd10;
   localparam logic [7:0] DEFAULT_ATTR_INIT = 8'd15;

   typedef enum logic {
      OP_PUT  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_BLANK
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic copy_rd;
      logic copy_wr;
      logic blank;
      logic finish_read;
      logic finish_put;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic need_scroll;
      logic copy_last;
      logic blank_last;
   } ctrl_status_type;

endpackage

FILE: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console over a COLUMNS x ROWS screen memory of
// character/attribute cells, with cursor, newline handling and scroll.
//
//   channel   ports            handshake
//   request   start, req_*     taken when start is high and busy is low
//   response  rsp_*            rsp_strobe high for one cycle, never stalled
//   config    csr_we, csr_*    written on any edge with csr_we high and reset low
//
// A put that does not scroll has its response registered from the execute
// state, a read from the read state after it. A put that runs off the last
// row scrolls: each cell below the top row is read and then written one row
// up, the last row is blanked, and the response follows the last blank.
// After reset busy stays high while the screen is cleared one cell per cycle.
// Responses cannot be held off; the next request is taken once busy drops.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_operation,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_attribute,
   input  logic       req_use_cursor,
   input  logic [6:0] req_column,
   input  logic [4:0] req_row,
   output logic       rsp_strobe,
   output logic [7:0] rsp_cell_char,
   output logic [7:0] rsp_cell_attribute,
   output logic [6:0] rsp_cursor_column,
   output logic [4:0] rsp_cursor_row,
   output logic       rsp_scrolled,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   tcw_pkg::ctrl_cmd_type    cmd;
   tcw_pkg::ctrl_status_type status;

   tcw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .status(status),
      .cmd   (cmd)
   );

   tcw_datapath #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_char_code     (req_char_code),
      .req_attribute     (req_attribute),
      .req_use_cursor    (req_use_cursor),
      .req_column        (req_column),
      .req_row           (req_row),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_strobe        (rsp_strobe),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attribute(rsp_cell_attribute),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_scrolled      (rsp_scrolled)
   );

endmodule

FILE: rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the text console writer: screen clear after reset, request
// execution, read return and the cell-by-cell scroll copy and blank.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  tcw_pkg::ctrl_status_type status,
   output tcw_pkg::ctrl_cmd_type    cmd
);

   tcw_pkg::state_type state_ff;
   tcw_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            cmd.blank = 1'b1;
            if (status.blank_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            priority if (status.is_read) begin
               state_in = tcw_pkg::ST_READ;
            end else if (status.need_scroll) begin
               state_in = tcw_pkg::ST_COPY_RD;
            end else begin
               cmd.finish_put = 1'b1;
               state_in       = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_READ: begin
            cmd.finish_read = 1'b1;
            state_in        = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_COPY_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = tcw_pkg::ST_COPY_WR;
         end
         tcw_pkg::ST_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            state_in    = status.copy_last ? tcw_pkg::ST_BLANK : tcw_pkg::ST_COPY_RD;
         end
         tcw_pkg::ST_BLANK: begin
            cmd.blank = 1'b1;
            if (status.blank_last) begin
               cmd.finish_put = 1'b1;
               state_in       = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Request registers, cursor, screen memory with its address and data muxing,
// sweep counter, default attribute register and response registers.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcw_pkg::ctrl_cmd_type    cmd,
   output tcw_pkg::ctrl_status_type status,
   input  logic                     req_operation,
   input  logic [7:0]               req_char_code,
   input  logic [7:0]               req_attribute,
   input  logic                     req_use_cursor,
   input  logic [6:0]               req_column,
   input  logic [4:0]               req_row,
   input  logic                     csr_we,
   input  logic [7:0]               csr_wdata,
   output logic                     rsp_strobe,
   output logic [7:0]               rsp_cell_char,
   output logic [7:0]               rsp_cell_attribute,
   output logic [6:0]               rsp_cursor_column,
   output logic [4:0]               rsp_cursor_row,
   output logic                     rsp_scrolled
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS + 1);

   logic           req_op_ff;
   logic [7:0]     req_char_ff;
   logic [7:0]     req_attr_ff;
   logic           req_cursor_ff;
   logic [6:0]     req_col_ff;
   logic [4:0]     req_row_ff;

   logic [7:0]     default_attr_ff;
   logic [CW-1:0]  cur_col_ff;
   logic [RW-1:0]  cur_row_ff;
   logic [AW-1:0]  idx_ff;

   logic           rsp_strobe_ff;
   logic [7:0]     rsp_char_ff;
   logic [7:0]     rsp_attr_ff;
   logic           rsp_scrolled_ff;

   logic [CW-1:0]  col_clamp;
   logic [RW-1:0]  row_clamp;
   logic [CW-1:0]  pos_col;
   logic [RW-1:0]  pos_row;
   logic [RW-1:0]  row_inc;
   logic [AW-1:0]  pos_addr;
   logic           newline;
   logic           wrap;
   logic [7:0]     attr_eff;
   logic [CW-1:0]  next_col;
   logic [RW-1:0]  next_row;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [15:0]    ram_wdata;
   logic [AW-1:0]  ram_raddr;
   logic [15:0]    ram_rdata;

   always_comb begin
      if (32'(req_col_ff) >= COLUMNS) begin
         col_clamp = CW'(COLUMNS - 1);
      end else begin
         col_clamp = CW'(req_col_ff);
      end
      if (32'(req_row_ff) >= ROWS) begin
         row_clamp = RW'(ROWS - 1);
      end else begin
         row_clamp = RW'(req_row_ff);
      end
      if (req_cursor_ff && (req_op_ff == tcw_pkg::OP_PUT)) begin
         pos_col = cur_col_ff;
         pos_row = cur_row_ff;
      end else begin
         pos_col = col_clamp;
         pos_row = row_clamp;
      end
      pos_addr = AW'(32'(pos_row) * COLUMNS + 32'(pos_col));
      newline  = (req_char_ff == tcw_pkg::NEWLINE_CODE);
      attr_eff = (req_attr_ff == 8'd0) ? default_attr_ff : req_attr_ff;
      wrap     = newline || (32'(pos_col) == COLUMNS - 1);
      row_inc  = pos_row + RW'(1);
      if (wrap) begin
         next_col = '0;
         next_row = (32'(row_inc) == ROWS) ? RW'(ROWS - 1) : row_inc;
      end else begin
         next_col = pos_col + CW'(1);
         next_row = pos_row;
      end
   end

   assign status.is_read     = (req_op_ff == tcw_pkg::OP_READ);
   assign status.need_scroll = wrap && (32'(row_inc) == ROWS);
   assign status.copy_last   = (32'(idx_ff) == CELLS - COLUMNS - 1);
   assign status.blank_last  = (32'(idx_ff) == CELLS - 1);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = '0;
      ram_raddr = '0;
      priority if (cmd.exec) begin
         ram_raddr = pos_addr;
         ram_waddr = pos_addr;
         ram_we    = (req_op_ff == tcw_pkg::OP_PUT) && !newline;
         ram_wdata = {attr_eff, req_char_ff};
      end else if (cmd.copy_rd) begin
         ram_raddr = idx_ff + AW'(COLUMNS);
      end else if (cmd.copy_wr) begin
         ram_we    = 1'b1;
         ram_wdata = ram_rdata;
      end else if (cmd.blank) begin
         ram_we    = 1'b1;
      end else begin
         ram_we    = 1'b0;
      end
   end

   tcw_ram #(
      .WIDTH(16),
      .DEPTH(CELLS)
   ) u_screen (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_op_ff     <= req_operation;
         req_char_ff   <= req_char_code;
         req_attr_ff   <= req_attribute;
         req_cursor_ff <= req_use_cursor;
         req_col_ff    <= req_column;
         req_row_ff    <= req_row;
      end
      if (cmd.finish_read) begin
         rsp_char_ff     <= ram_rdata[7:0];
         rsp_attr_ff     <= ram_rdata[15:8];
         rsp_scrolled_ff <= 1'b0;
      end else if (cmd.finish_put) begin
         rsp_char_ff     <= '0;
         rsp_attr_ff     <= '0;
         rsp_scrolled_ff <= !cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= tcw_pkg::DEFAULT_ATTR_INIT;
         cur_col_ff      <= '0;
         cur_row_ff      <= '0;
         idx_ff          <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            default_attr_ff <= csr_wdata;
         end
         if (cmd.exec && (req_op_ff == tcw_pkg::OP_PUT)) begin
            cur_col_ff <= next_col;
            cur_row_ff <= next_row;
         end
         if (cmd.blank && status.blank_last) begin
            idx_ff <= '0;
         end else if (cmd.copy_wr || cmd.blank) begin
            idx_ff <= idx_ff + AW'(1);
         end
         rsp_strobe_ff <= cmd.finish_read || cmd.finish_put;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_cell_char      = rsp_char_ff;
   assign rsp_cell_attribute = rsp_attr_ff;
   assign rsp_cursor_column  = 7'(cur_col_ff);
   assign rsp_cursor_row     = 5'(cur_row_ff);
   assign rsp_scrolled       = rsp_scrolled_ff;

endmodule

FILE: dv/text_console_checker.sv
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the request, response and register channels of the text console
// writer, keeps its own copy of the screen, cursor and default attribute,
// and compares every response field by field against the oldest reply due.
// ----------------------------------------------------------------------------
module text_console_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic       req_operation,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_attribute,
   input  logic       req_use_cursor,
   input  logic [6:0] req_column,
   input  logic [4:0] req_row,
   input  logic       rsp_strobe,
   input  logic [7:0] rsp_cell_char,
   input  logic [7:0] rsp_cell_attribute,
   input  logic [6:0] rsp_cursor_column,
   input  logic [4:0] rsp_cursor_row,
   input  logic       rsp_scrolled,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output int         replies_due,
   output int         error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS  = tcw_pkg::COLUMNS_DEFAULT;
   localparam int LINES = tcw_pkg::ROWS_DEFAULT;
   localparam int CELLS = COLS * LINES;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [7:0] cell_attribute;
      logic [6:0] cursor_column;
      logic [4:0] cursor_row;
      logic       scrolled;
   } console_reply_type;

   logic [15:0]       screen [CELLS];
   int unsigned       cursor_cell;
   logic [7:0]        default_attr;
   console_reply_type console_replies [$];

   function automatic int unsigned clamp_cell(logic [6:0] column, logic [4:0] row);
      int unsigned c;
      int unsigned r;
      c = column;
      r = row;
      if (c >= COLS) c = COLS - 1;
      if (r >= LINES) r = LINES - 1;
      return r * COLS + c;
   endfunction

   function automatic console_reply_type console_step(logic op, logic [7:0] char_code,
                                                      logic [7:0] attribute,
                                                      logic use_cursor,
                                                      logic [6:0] column, logic [4:0] row);
      console_reply_type reply;
      int unsigned       pos;
      logic [7:0]        attr;
      reply = '0;
      if (op == tcw_pkg::OP_READ) begin
         {reply.cell_attribute, reply.cell_char} = screen[clamp_cell(column, row)];
      end else begin
         pos = use_cursor ? cursor_cell : clamp_cell(column, row);
         if (pos >= CELLS) pos = CELLS - 1;
         attr = (attribute == 8'd0) ? default_attr : attribute;
         if (char_code == tcw_pkg::NEWLINE_CODE) begin
            pos = (pos / COLS) * COLS + (COLS - 1);
         end else begin
            screen[pos] = {attr, char_code};
         end
         cursor_cell = pos + 1;
         if (cursor_cell >= CELLS) begin
            for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
            cursor_cell -= COLS;
            reply.scrolled = 1'b1;
         end
      end
      reply.cursor_column = 7'(cursor_cell % COLS);
      reply.cursor_row    = 5'(cursor_cell / COLS);
      return reply;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      console_reply_type want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) screen[i] = '0;
         cursor_cell  = 0;
         default_attr = tcw_pkg::DEFAULT_ATTR_INIT;
         console_replies.delete();
         replies_due <= 0;
      end else begin
         if (csr_we) default_attr = csr_wdata;
         if (rsp_strobe) begin
            if (console_replies.size() == 0) begin
               $display("%0t: response with none due, expected none, actual %h", $time,
                        {rsp_cell_char, rsp_cell_attribute, rsp_cursor_column,
                         rsp_cursor_row, rsp_scrolled});
               error_count++;
            end else begin
               want = console_replies.pop_front();
               check_field("cell_char", want.cell_char, rsp_cell_char);
               check_field("cell_attribute", want.cell_attribute, rsp_cell_attribute);
               check_field("cursor_column", want.cursor_column, rsp_cursor_column);
               check_field("cursor_row", want.cursor_row, rsp_cursor_row);
               check_field("scrolled", want.scrolled, rsp_scrolled);
            end
         end
         if (start && !busy) begin
            console_replies.push_back(console_step(req_operation, req_char_code,
                                                   req_attribute, req_use_cursor,
                                                   req_column, req_row));
         end
         replies_due <= console_replies.size();
      end
   end

endmodule

FILE: dv/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Drives directed and random put and read requests into the text console
// writer across several default attribute settings, with random sender gaps
// outside phases 4 and 5; the verdict is from the checker's error count.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASES         = 10;
   localparam int PHASE_REQUESTS = 100;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_operation = tcw_pkg::OP_PUT;
   logic [7:0] req_char_code = '0;
   logic [7:0] req_attribute = '0;
   logic       req_use_cursor = 1'b0;
   logic [6:0] req_column = '0;
   logic [4:0] req_row = '0;
   logic       rsp_strobe;
   logic [7:0] rsp_cell_char;
   logic [7:0] rsp_cell_attribute;
   logic [6:0] rsp_cursor_column;
   logic [4:0] rsp_cursor_row;
   logic       rsp_scrolled;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = '0;
   int         replies_due;
   int         error_count;
   int         quiet_cycles = 0;
   bit         gaps_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_writer dut (.*);

   text_console_checker console_check (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic issue_request(tcw_pkg::op_type op, logic [7:0] char_code,
                                logic [7:0] attribute, logic use_cursor,
                                logic [6:0] column, logic [4:0] row);
      int gap;
      gap = 0;
      if (gaps_on) while ($urandom_range(99) < 21) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation  <= op;
      req_char_code  <= char_code;
      req_attribute  <= attribute;
      req_use_cursor <= use_cursor;
      req_column     <= column;
      req_row        <= row;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (replies_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_default_attr(logic [7:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_request();
      tcw_pkg::op_type op;
      logic [7:0]      char_code;
      logic [7:0]      attribute;
      logic [6:0]      column;
      logic [4:0]      row;
      op        = ($urandom_range(99) < 30) ? tcw_pkg::OP_READ : tcw_pkg::OP_PUT;
      char_code = ($urandom_range(99) < 6) ? tcw_pkg::NEWLINE_CODE : 8'($urandom_range(255));
      attribute = ($urandom_range(99) < 20) ? 8'd0 : 8'($urandom_range(255));
      column    = ($urandom_range(99) < 15) ? 7'($urandom_range(127, 80))
                                            : 7'($urandom_range(79));
      row       = ($urandom_range(99) < 15) ? 5'($urandom_range(31, 25))
                                            : 5'($urandom_range(24));
      issue_request(op, char_code, attribute, 1'($urandom_range(1)), column, row);
   endtask

   task automatic run_off_bottom(inout int issued);
      int run;
      run = $urandom_range(25, 1);
      issue_request(tcw_pkg::OP_PUT, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0,
                    7'($urandom_range(79, 60)), 5'd24);
      repeat (run) begin
         issue_request(tcw_pkg::OP_PUT, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       1'b1, 7'($urandom_range(127)), 5'($urandom_range(31)));
      end
      issued += run + 1;
   endtask

   initial begin
      int         issued;
      logic [7:0] attr_setting;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      issue_request(tcw_pkg::OP_PUT, 8'h41, 8'd0, 1'b1, 7'd0, 5'd0);
      issue_request(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 7'd0, 5'd0);
      issue_request(tcw_pkg::OP_PUT, 8'd0, 8'hFF, 1'b0, 7'd127, 5'd31);
      issue_request(tcw_pkg::OP_READ, 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31);
      issue_request(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 7'd0, 5'd0);
      issue_request(tcw_pkg::OP_PUT, 8'hFF, 8'd1, 1'b0, 7'd79, 5'd0);
      issue_request(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 8'd0, 1'b1, 7'd0, 5'd0);
      issue_request(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 8'h80, 1'b0, 7'd5, 5'd24);
      issue_request(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 8'd7, 1'b0, 7'd127, 5'd10);
      issue_request(tcw_pkg::OP_PUT, 8'h5A, 8'h80, 1'b1, 7'd0, 5'd0);
      issue_request(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 7'd0, 5'd11);
      issue_request(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 7'd0, 5'd31);
      issue_request(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 7'd127, 5'd0);
      issue_request(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 7'd79, 5'd23);
      issue_request(tcw_pkg::OP_PUT, 8'h7F, 8'h01, 1'b0, 7'd80, 5'd25);
      issue_request(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b1, 7'd79, 5'd24);
      set_default_attr(8'd0);
      issue_request(tcw_pkg::OP_PUT, 8'h30, 8'd0, 1'b0, 7'd40, 5'd12);
      issue_request(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 7'd40, 5'd12);
      set_default_attr(8'hFF);
      issue_request(tcw_pkg::OP_PUT, 8'h31, 8'd0, 1'b1, 7'd0, 5'd0);
      issue_request(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 7'd41, 5'd12);

      for (int phase = 0; phase < PHASES; phase++) begin
         unique case (phase % 4)
            0:       attr_setting = 8'd0;
            1:       attr_setting = 8'hFF;
            2:       attr_setting = tcw_pkg::DEFAULT_ATTR_INIT;
            default: attr_setting = 8'($urandom_range(255));
         endcase
         set_default_attr(attr_setting);
         gaps_on = !(phase == 4 || phase == 5);
         issued  = 0;
         while (issued < PHASE_REQUESTS) begin
            if ($urandom_range(99) < 4) begin
               run_off_bottom(issued);
            end else begin
               random_request();
               issued++;
            end
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
